FILE: src/ksc_pkg.sv
// ksc_pkg: shared types and constants for the keyword substitution cipher.
// Used by ksc_ctrl, ksc_datapath and keyword_substitution_cipher.
`default_nettype none

package ksc_pkg;

    localparam int unsigned LETTERS  = 26;
    localparam int unsigned LETTER_W = 5;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_TAKEN   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_READY   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic fill;     // one step of the reversed-alphabet fill
        logic invert;   // one step of the inverse-table build
        logic finish;   // post the tables-ready result
    } ksc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register empty or draining this cycle
        logic finish_req;  // pending input is a key item marked last
        logic cnt_zero;
        logic cnt_top;
    } ksc_stat_t;

endpackage

`default_nettype wire

FILE: src/keyword_substitution_cipher.sv
// keyword_substitution_cipher: data items and key items not marked last are registered into the output register;
// one item per cycle while the result side keeps up and no table completion is running.
// A key item marked last holds off input for a 26-step fill walk (Z down to A) and a
// 26-step inverse build over the single cipher read port before its tables-ready result.
// Async active-low reset: tables to identity, key state cleared, direction 0, output empty.
// Depends on ksc_pkg, ksc_ctrl and ksc_datapath.
`default_nettype none

module keyword_substitution_cipher (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // direction register write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    // input items
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] value,
    input  wire logic       key_last,
    // result items
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      status
);

    ksc_pkg::ksc_cmd_t  cmd;
    ksc_pkg::ksc_stat_t stat;

    // direction is a plain register; a write transfer completes at once
    assign cfg_ready = 1'b1;

    // Controller: gates input transfers on a free output register and
    // sequences the fill and inverse passes after the key item marked last.
    ksc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: both tables, used-letter set, key count, step counter,
    // and the output register that parts input from result side.
    ksc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .value     (value),
        .key_last  (key_last),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .status    (status)
    );

endmodule

`default_nettype wire

FILE: src/ksc_ctrl.sv
// ksc_ctrl: sequencer for item acceptance and the two-pass table completion.
// Depends on ksc_pkg.
`default_nettype none

module ksc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ksc_pkg::ksc_stat_t stat,
    output ksc_pkg::ksc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FILL   = 3'b010,
        S_INVERT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept && stat.finish_req)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_INVERT;
                end
            end
            S_INVERT:
            begin
                cmd.invert = 1'b1;
                // last inverse write repeats harmlessly until the output frees
                if (stat.cnt_top && stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ksc_datapath.sv
// ksc_datapath: cipher and inverse tables, key state, step counter, output register.
// Depends on ksc_pkg; driven by ksc_ctrl commands.
`default_nettype none

module ksc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               req_type,
    input  wire logic [7:0]         value,
    input  wire logic               key_last,
    input  wire logic               out_ready,
    input  wire ksc_pkg::ksc_cmd_t  cmd,
    output ksc_pkg::ksc_stat_t      stat,
    output logic                    out_valid,
    output logic [7:0]              out_byte,
    output logic [1:0]              status
);

    localparam int unsigned LW = ksc_pkg::LETTER_W;

    logic [LW-1:0] cipher_reg  [ksc_pkg::LETTERS];
    logic [LW-1:0] inverse_reg [ksc_pkg::LETTERS];

    logic [ksc_pkg::LETTERS-1:0] used_reg, used_next;
    logic [LW-1:0]               key_count_reg, key_count_next;
    logic                        loading_reg, loading_next;
    logic [LW-1:0]               cnt_reg, cnt_next;
    logic                        direction_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic [1:0]                  status_reg, status_next;

    logic [7:0]                  diff;
    logic [LW-1:0]               idx;
    logic                        is_letter;
    logic [ksc_pkg::LETTERS-1:0] used_eff;
    logic [LW-1:0]               kc_eff;
    logic                        take;
    logic                        is_key;
    logic [LW-1:0]               cipher_addr;
    logic [LW-1:0]               cipher_rd;
    logic [LW-1:0]               inverse_rd;
    logic [LW-1:0]               mapped;
    logic [7:0]                  data_byte;
    logic                        fill_write;

    assign diff      = value - ksc_pkg::CHAR_A;
    assign idx       = diff[LW-1:0];
    assign is_letter = (value >= ksc_pkg::CHAR_A) && (value <= ksc_pkg::CHAR_Z);
    assign is_key    = (req_type == ksc_pkg::REQ_KEY);

    // a key item that starts a new key sees a cleared letter set and count
    assign used_eff = loading_reg ? used_reg : '0;
    assign kc_eff   = loading_reg ? key_count_reg : '0;
    assign take     = is_key && is_letter && !used_eff[idx]
                      && (kc_eff < LW'(ksc_pkg::LETTERS));

    assign cipher_addr = cmd.invert ? cnt_reg : idx;
    assign cipher_rd   = cipher_reg[cipher_addr];
    assign inverse_rd  = inverse_reg[idx];
    assign mapped      = direction_reg ? inverse_rd : cipher_rd;
    assign data_byte   = is_letter ? (ksc_pkg::CHAR_A + {3'b000, mapped}) : value;

    assign fill_write = cmd.fill && !used_reg[cnt_reg];

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.finish_req = is_key && key_last;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_top    = (cnt_reg == ksc_pkg::LAST_LETTER);

    always_comb
    begin
        used_next      = used_reg;
        key_count_next = key_count_reg;
        loading_next   = loading_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        status_next    = status_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            if (is_key)
            begin
                loading_next   = 1'b1;
                used_next      = used_eff;
                key_count_next = kc_eff;
                if (take)
                begin
                    used_next[idx] = 1'b1;
                    key_count_next = kc_eff + LW'(1);
                end
            end
            if (stat.finish_req)
            begin
                cnt_next = ksc_pkg::LAST_LETTER;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_byte_next  = is_key ? 8'h00 : data_byte;
                status_next    = !is_key ? ksc_pkg::ST_DATA
                               : (take ? ksc_pkg::ST_TAKEN : ksc_pkg::ST_DROPPED);
            end
        end

        if (cmd.fill)
        begin
            if (fill_write)
            begin
                used_next[cnt_reg] = 1'b1;
                key_count_next     = key_count_reg + LW'(1);
            end
            if (!stat.cnt_zero)
            begin
                cnt_next = cnt_reg - LW'(1);
            end
        end

        if (cmd.invert && !stat.cnt_top)
        begin
            cnt_next = cnt_reg + LW'(1);
        end

        if (cmd.finish)
        begin
            loading_next   = 1'b0;
            out_valid_next = 1'b1;
            out_byte_next  = 8'h00;
            status_next    = ksc_pkg::ST_READY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            key_count_reg <= '0;
            loading_reg   <= 1'b0;
            cnt_reg       <= '0;
            direction_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            key_count_reg <= key_count_next;
            loading_reg   <= loading_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                direction_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        status_reg   <= status_next;
    end

    // tables reset to identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ksc_pkg::LETTERS; i++)
            begin
                cipher_reg[i]  <= LW'(i);
                inverse_reg[i] <= LW'(i);
            end
        end
        else
        begin
            if (cmd.accept && take)
            begin
                cipher_reg[kc_eff] <= idx;
            end
            if (fill_write)
            begin
                cipher_reg[key_count_reg] <= cnt_reg;
            end
            if (cmd.invert)
            begin
                inverse_reg[cipher_rd] <= cnt_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
